[sv/dlu_pkg.sv]
//------------------------------------------------------------------------------
// dlu_pkg
// Shared constants and types for the dense LU factor block.
//------------------------------------------------------------------------------
`default_nettype none

package dlu_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_ORDER);
    localparam int ORD_W       = 4;
    localparam int CNT_W       = 7;

    localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(MAX_ORDER);

    // configuration register indexes
    localparam logic [0:0] REG_MATRIX_ORDER = 1'b0;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    // sequencer states
    typedef enum logic [10:0] {
        ST_LOAD   = 11'b000_0000_0001,
        ST_PIVRD  = 11'b000_0000_0010,
        ST_PIVWT  = 11'b000_0000_0100,
        ST_NUMRD  = 11'b000_0000_1000,
        ST_NUMWT  = 11'b000_0001_0000,
        ST_DIV    = 11'b000_0010_0000,
        ST_UPRD   = 11'b000_0100_0000,
        ST_UPWT   = 11'b000_1000_0000,
        ST_UPMUL  = 11'b001_0000_0000,
        ST_UPWR   = 11'b010_0000_0000,
        ST_EMIT   = 11'b100_0000_0000
    } t_state;

endpackage

`default_nettype wire

[sv/dense_lu_factor_block_top.sv]
//------------------------------------------------------------------------------
// dense_lu_factor_block_top
// In-place LU factorization (L with diagonal, unit-upper U), Q16.16, no pivot.
//------------------------------------------------------------------------------
// channel  | signals                                   | direction
// request  | i_start, o_busy, i_element_value          | in/out
// result   | o_valid, o_factor_value, o_last_entry,    | out
//          | o_zero_pivot_seen, o_saturated_seen       |
// config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//          | prdata, pready                            |
//
// A load request is taken when not busy. The n*n-th request starts factoring:
// each pivot is fetched in a read and a wait state, each quotient needs a
// numerator fetch and a 48-step restoring divider, each update entry passes
// read, wait, multiply and write states via the single store read port and
// one 32x32 multiplier. Then n*n results stream out one per cycle, each in the
// cycle after its read; busy falls in the cycle the last result is on the ports.
// Reset is synchronous; the store itself is not cleared. No output stall.
//------------------------------------------------------------------------------
`default_nettype none

module dense_lu_factor_block_top
    import dlu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_element_value,
    output logic             o_valid,
    output logic [31:0]      o_factor_value,
    output logic             o_last_entry,
    output logic             o_zero_pivot_seen,
    output logic             o_saturated_seen,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state r_state;
    logic [ORD_W-1:0]  r_order;
    logic [CNT_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  r_n1;      // active order minus one
    logic [IDX_W-1:0]  r_k, r_j, r_r;
    logic [ADDR_W-1:0] r_emit;
    logic [ADDR_W-1:0] r_last_idx; // index of the final entry to emit
    logic              r_zp, r_sat;
    logic [31:0]       mem [STORE_DEPTH];
    logic [31:0]       r_rd;
    logic signed [31:0] r_piv, r_q, r_l;
    logic signed [63:0] r_prod;
    // divider
    logic [5:0]        r_dcnt;
    logic [47:0]       r_dquo;
    logic [32:0]       r_drem;
    logic [31:0]       r_ddiv;
    logic              r_dneg;

    // active order
    logic [IDX_W:0] n_eff;
    always_comb begin
        if (r_order == '0) n_eff = (IDX_W+1)'(1);
        else if (r_order > ORD_W'(MAX_ORDER)) n_eff = (IDX_W+1)'(MAX_ORDER);
        else n_eff = r_order[IDX_W:0];
    end

    // address r + c*n
    function automatic logic [ADDR_W-1:0] addr_of(logic [IDX_W-1:0] r,
            logic [IDX_W-1:0] c, logic [IDX_W-1:0] n1);
        logic [ADDR_W:0] a;
        a = (ADDR_W+1)'(r) + (ADDR_W+1)'(c) * ((ADDR_W+1)'(n1) + 1'b1);
        return a[ADDR_W-1:0];
    endfunction

    logic accept, cfg_wr;
    assign accept = i_start && !o_busy;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MATRIX_ORDER) ? {28'd0, r_order} : 32'd0;
    assign o_busy = (r_state != ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_order <= ORDER_RESET;
        else if (cfg_wr && paddr == REG_MATRIX_ORDER) r_order <= pwdata[ORD_W-1:0];
    end

    // total entries and load bound
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] total;
    assign cnt_next = r_cnt + 1'b1;
    assign total    = CNT_W'(n_eff) * CNT_W'(n_eff);

    // quotient sign-magnitude set-up and clamp
    logic [31:0] num_abs, piv_abs;
    logic signed [63:0] q_signed, upd;
    logic [32:0] trial;
    logic signed [31:0] num_s;
    assign num_s   = r_rd;
    assign num_abs = num_s[31] ? 32'(-num_s) : num_s;
    assign piv_abs = r_piv[31] ? 32'(-r_piv) : r_piv;
    assign trial   = {r_drem[31:0], r_dquo[47]} - {1'b0, r_ddiv};
    assign q_signed = r_dneg ? -$signed({16'd0, r_dquo}) : $signed({16'd0, r_dquo});
    assign upd = 64'($signed(r_rd)) - (r_prod >>> 16);

    // address for the single store port read
    logic [ADDR_W-1:0] rd_addr;
    always_comb begin
        case (r_state)
            ST_PIVRD: rd_addr = addr_of(r_k, r_k, r_n1);
            ST_NUMRD: rd_addr = addr_of(r_k, r_j, r_n1);
            ST_UPRD:  rd_addr = addr_of(r_r, r_k, r_n1);
            // hold the entry being updated in r_rd until its write
            ST_UPWT, ST_UPMUL: rd_addr = addr_of(r_r, r_j, r_n1);
            default:  rd_addr = r_emit;
        endcase
    end

    // store write
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [31:0]       wd;
    logic              sat_q, sat_u;
    logic [31:0]       q_cl, u_cl;
    always_comb begin
        sat_q = (q_signed > Q_MAX) || (q_signed < Q_MIN);
        q_cl  = (q_signed > Q_MAX) ? 32'h7FFF_FFFF :
                (q_signed < Q_MIN) ? 32'h8000_0000 : q_signed[31:0];
        sat_u = (upd > Q_MAX) || (upd < Q_MIN);
        u_cl  = (upd > Q_MAX) ? 32'h7FFF_FFFF :
                (upd < Q_MIN) ? 32'h8000_0000 : upd[31:0];
        we = 1'b0; wa = '0; wd = '0;
        if (accept) begin
            we = 1'b1; wa = r_cnt[ADDR_W-1:0]; wd = i_element_value;
        end else if (r_state == ST_DIV && r_dcnt == 6'd48) begin
            we = 1'b1; wa = addr_of(r_k, r_j, r_n1);
            wd = (r_piv == 0) ? 32'd0 : q_cl;
        end else if (r_state == ST_UPWR) begin
            we = 1'b1; wa = addr_of(r_r, r_j, r_n1); wd = u_cl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_zp    <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: if (accept) begin
                    if (cnt_next >= total) begin
                        r_cnt <= '0;
                        r_n1  <= IDX_W'(n_eff - 1'b1);
                        r_k   <= '0;
                        r_zp  <= 1'b0;
                        r_sat <= 1'b0;
                        r_emit <= '0;
                        r_last_idx <= ADDR_W'(total - 1'b1);
                        r_state <= ST_PIVRD;
                    end else r_cnt <= cnt_next;
                end
                ST_PIVRD: r_state <= ST_PIVWT;
                ST_PIVWT: begin
                    r_piv <= r_rd;
                    if (r_k == r_n1) r_state <= ST_EMIT;
                    else begin
                        r_j <= r_k + 1'b1;
                        r_state <= ST_NUMRD;
                    end
                end
                ST_NUMRD: r_state <= ST_NUMWT;
                ST_NUMWT: begin
                    r_dquo  <= {num_abs, 16'd0};
                    r_drem  <= '0;
                    r_ddiv  <= piv_abs;
                    r_dneg  <= num_s[31] ^ r_piv[31];
                    r_dcnt  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_dcnt == 6'd48) begin
                        if (r_piv == 0) begin
                            r_zp <= 1'b1; r_q <= '0;
                        end else begin
                            r_q <= q_cl;
                            if (sat_q) r_sat <= 1'b1;
                        end
                        r_r <= r_k + 1'b1;
                        r_state <= ST_UPRD;
                    end else begin
                        // one restoring step per cycle
                        if (!trial[32]) begin
                            r_drem <= trial;
                            r_dquo <= {r_dquo[46:0], 1'b1};
                        end else begin
                            r_drem <= {r_drem[31:0], r_dquo[47]};
                            r_dquo <= {r_dquo[46:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                ST_UPRD: r_state <= ST_UPWT;
                ST_UPWT: begin
                    r_l <= r_rd;
                    r_state <= ST_UPMUL;
                end
                ST_UPMUL: begin
                    r_prod <= r_q * r_l;
                    r_state <= ST_UPWR;
                end
                ST_UPWR: begin
                    if (sat_u) r_sat <= 1'b1;
                    if (r_r != r_n1) begin
                        r_r <= r_r + 1'b1;
                        r_state <= ST_UPRD;
                    end else if (r_j != r_n1) begin
                        r_j <= r_j + 1'b1;
                        r_state <= ST_NUMRD;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= ST_PIVRD;
                    end
                end
                ST_EMIT: begin
                    // one read per cycle; the data shows up on the next one
                    r_emit <= r_emit + 1'b1;
                    if (r_emit == r_last_idx) r_state <= ST_LOAD;
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // result path: each emit read lands in r_rd, with valid and last registered beside it
    logic r_emv, r_eml;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emv <= 1'b0;
            r_eml <= 1'b0;
        end else begin
            r_emv <= (r_state == ST_EMIT);
            r_eml <= (r_state == ST_EMIT) && (r_emit == r_last_idx);
        end
    end

    assign o_valid           = r_emv;
    assign o_factor_value    = r_rd;
    assign o_last_entry      = r_eml;
    assign o_zero_pivot_seen = r_zp;
    assign o_saturated_seen  = r_sat;

    // assertions
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eml |-> r_emv) else $error("last without valid");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> o_busy) else $error("divide while idle");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eml |=> !r_emv) else $error("result after last");

endmodule

`default_nettype wire

[test/dense_lu_factor_block_top_test.sv]
//------------------------------------------------------------------------------
// dense_lu_factor_block_top_test
// Self-checking bench for the dense LU factor block: loads matrices of several
// orders, predicts the in-place Q16.16 factorization and checks every entry.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module dense_lu_factor_block_top_test;
    import dlu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        zero_piv;
        logic        sat;
    } t_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_element_value;
    logic        o_valid;
    logic [31:0] o_factor_value;
    logic        o_last_entry;
    logic        o_zero_pivot_seen;
    logic        o_saturated_seen;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dense_lu_factor_block_top uut (.*);

    // shadow of the block
    logic [31:0]      lu_store [STORE_DEPTH];
    logic [CNT_W-1:0] load_cnt;
    logic [ORD_W-1:0] order_reg;
    bit               zp_flag;
    bit               sat_flag;

    t_entry pending_entries[$];
    int     mismatches;
    int     requests_sent;
    int     matrices_done;
    int     idle_cycles;
    bit     calm;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp_q(longint v);
        if (v > Q_MAX) begin
            sat_flag = 1'b1;
            v = Q_MAX;
        end
        if (v < Q_MIN) begin
            sat_flag = 1'b1;
            v = Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic int eff_order();
        int n;
        n = order_reg;
        if (n < 1) n = 1;
        if (n > MAX_ORDER) n = MAX_ORDER;
        return n;
    endfunction

    // Crout elimination, in place on the shadow store
    function automatic void factor_matrix(int n);
        longint piv, num, q, l, cur, prod;
        for (int k = 0; k < n; k++) begin
            piv = longint'(signed'(lu_store[k + k*n]));
            for (int j = k + 1; j < n; j++) begin
                num = longint'(signed'(lu_store[k + j*n]));
                if (piv == 0) begin
                    zp_flag = 1'b1;
                    lu_store[k + j*n] = '0;
                end else begin
                    lu_store[k + j*n] = clamp_q((num * 65536) / piv);
                end
                q = longint'(signed'(lu_store[k + j*n]));
                for (int r = k + 1; r < n; r++) begin
                    l    = longint'(signed'(lu_store[r + k*n]));
                    cur  = longint'(signed'(lu_store[r + j*n]));
                    prod = (q * l) >>> 16;
                    lu_store[r + j*n] = clamp_q(cur - prod);
                end
            end
        end
    endfunction

    function automatic void load_entry(logic [31:0] v);
        int n;
        t_entry e;
        n = eff_order();
        lu_store[load_cnt[ADDR_W-1:0]] = v;
        load_cnt = load_cnt + 1'b1;
        if (load_cnt >= n*n) begin
            load_cnt = '0;
            zp_flag  = 1'b0;
            sat_flag = 1'b0;
            factor_matrix(n);
            for (int i = 0; i < n*n; i++) begin
                e.value    = lu_store[i];
                e.last     = (i == n*n - 1);
                e.zero_piv = zp_flag;
                e.sat      = sat_flag;
                pending_entries.push_back(e);
            end
            matrices_done++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch %s: got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // request and result monitor, watchdog
    always @(posedge i_clk) begin
        t_entry e;
        bit     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_start && !o_busy) begin
                load_entry(i_element_value);
                moved = 1'b1;
            end
            if (o_valid) begin
                moved = 1'b1;
                if (pending_entries.size() == 0) begin
                    report_mismatch("unexpected result", o_factor_value, '0);
                end else begin
                    e = pending_entries.pop_front();
                    if (o_factor_value !== e.value)
                        report_mismatch("factor_value", o_factor_value, e.value);
                    if (o_last_entry !== e.last)
                        report_mismatch("last_entry", 32'(o_last_entry), 32'(e.last));
                    if (o_zero_pivot_seen !== e.zero_piv)
                        report_mismatch("zero_pivot_seen", 32'(o_zero_pivot_seen),
                                        32'(e.zero_piv));
                    if (o_saturated_seen !== e.sat)
                        report_mismatch("saturated_seen", 32'(o_saturated_seen),
                                        32'(e.sat));
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one load request, with random gaps ahead of it
    task automatic send_element(logic [31:0] v);
        if (!calm && $urandom_range(99) < 22) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (o_busy);
        requests_sent++;
    endtask

    // drain results and let the block settle before touching the register
    task automatic wait_quiet();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_entries.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write followed by a read-back
    task automatic set_order(logic [ORD_W-1:0] ord);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MATRIX_ORDER;
        pwdata  <= 32'(ord);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        order_reg = ord;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[ORD_W-1:0] !== ord)
            report_mismatch("matrix_order readback", prdata, 32'(ord));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] small_q();
        return 32'($urandom_range(0, 524288)) - 32'd262144;
    endfunction

    // single-entry matrices at the value extremes
    task automatic test_extremes();
        set_order(4'd1);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        set_order(4'd0);
        send_element(32'hFFFF_FFFF);
    endtask

    // zero pivot and a clamped quotient
    task automatic test_special_cases();
        set_order(4'd2);
        send_element(32'h0000_0000);
        send_element(32'h0001_0000);
        send_element(32'h0003_0000);
        send_element(32'h0002_0000);
        send_element(32'h0000_0001);
        send_element(32'h8000_0000);
        send_element(32'h7FFF_FFFF);
        send_element(32'h7FFF_FFFF);
    endtask

    // order lowered part way through a load: next request factors at once
    task automatic test_order_change_mid_load();
        set_order(4'd3);
        for (int i = 0; i < 5; i++) send_element(small_q());
        set_order(4'd2);
        send_element(small_q());
    endtask

    // random matrices over several orders, mostly well conditioned
    task automatic test_random();
        logic [ORD_W-1:0] ord;
        int n, mode;
        while (requests_sent < 280) begin
            case ($urandom_range(5))
                0:       ord = 4'd8;
                1:       ord = 4'd15;
                2:       ord = 4'd1;
                default: ord = 4'($urandom_range(2, 5));
            endcase
            set_order(ord);
            n    = eff_order();
            mode = $urandom_range(9);
            calm = (requests_sent > 120 && requests_sent < 190);
            for (int i = 0; i < n*n; i++) begin
                if (mode < 2)
                    send_element($urandom);
                else if (i % (n + 1) == 0)
                    send_element(small_q() + 32'h0008_0000);
                else if (mode == 2 && $urandom_range(3) == 0)
                    send_element(32'h0000_0000);
                else
                    send_element(small_q());
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_element_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < STORE_DEPTH; i++) lu_store[i] = '0;
        load_cnt = '0;
        order_reg = ORDER_RESET;
        zp_flag = 1'b0;
        sat_flag = 1'b0;
        mismatches = 0;
        requests_sent = 0;
        matrices_done = 0;
        idle_cycles = 0;
        calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_special_cases();
        test_order_change_mid_load();
        test_random();

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d load requests and %0d factored matrices of orders 1 to 8,",
                 requests_sent, matrices_done);
        $display("including zero pivots, clamped results and an order change mid-load.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
